/* design/rwv_pkg.sv */
// ----------------------------------------------------------------------------
// rwv_pkg: shared types and constants of the rolling window vwap block
// Field widths, reset values, opcodes and the divider status bundle.
// ----------------------------------------------------------------------------
package rwv_pkg;

  // fixed field widths
  localparam int VALUE_W  = 40;
  localparam int VOLUME_W = 24;
  localparam int PRICE_W  = 63;
  localparam int LEN_W    = 7;

  // largest length the register can hold
  localparam int LEN_REG_MAX = 127;

  // parameter defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // window length after reset
  localparam logic [LEN_W-1:0] WINDOW_RESET = 7'd64;

  // item opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* design/rwv_ram.sv */
// ----------------------------------------------------------------------------
// rwv_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/rwv_divider.sv */
// ----------------------------------------------------------------------------
// rwv_divider: bit-serial restoring divider
// Computes floor(num * 2^FRAC / den), one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rwv_divider #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 30,
  parameter int FRAC  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  output logic [NUM_W+FRAC-1:0]   quotient,
  output rwv_pkg::div_status_t    status
);

  localparam int SR_W  = NUM_W + FRAC;
  localparam int CNT_W = $clog2(SR_W + 1);

  logic [SR_W-1:0]  quot;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // one restoring step: bring in the next numerator bit and try the subtract
  always_comb begin
    trial    = {rem, quot[SR_W-1]};
    diff     = trial - {1'b0, den_q};
    fits     = (trial >= {1'b0, den_q});
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // numerator shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot  <= SR_W'(num) << FRAC;
        rem   <= '0;
        den_q <= den;
        count <= CNT_W'(SR_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quot  <= {quot[SR_W-2:0], fits};
        rem   <= rem_next;
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quot;
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* design/rolling_window_vwap.sv */
// ----------------------------------------------------------------------------
// rolling_window_vwap: windowed volume weighted average price
// Keeps the last window_length samples in a ring memory with running totals
// and reports floor(value_total * 2^FRAC_BITS / volume_total) per item.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  payload
//  -------  -------------------------  ----------------------------------------
//  in       in_valid / in_stall        opcode, trade_value, trade_volume
//  out      out_valid / out_stall      vwap_price, window_full, zero_volume
//  cfg      cfg_wr_en                  cfg_wr_data (window_length)
//
//  A push steps through evict, insert, start, divide and done, a clear item
//  through evict, start and done, skipping the divider, as does a push that
//  leaves the volume total at zero. The bit-serial divider produces one
//  quotient bit per cycle. The result is registered as the sequencer returns
//  to idle; no new item is taken before that. Reset is synchronous and
//  needs no clearing pass. A stalled result waits in the output register
//  while the next item is accepted and worked on.
//
module rolling_window_vwap #(
  parameter int MAX_WINDOW = rwv_pkg::MAX_WINDOW_DEF,
  parameter int FRAC_BITS  = rwv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [rwv_pkg::VALUE_W-1:0]  trade_value,
  input  logic [rwv_pkg::VOLUME_W-1:0] trade_volume,
  // results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rwv_pkg::PRICE_W-1:0]  vwap_price,
  output logic                         window_full,
  output logic                         zero_volume,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [rwv_pkg::LEN_W-1:0]    cfg_wr_data
);

  localparam int LEN_MAX = (MAX_WINDOW < rwv_pkg::LEN_REG_MAX) ?
                           MAX_WINDOW : rwv_pkg::LEN_REG_MAX;
  localparam int LOG_LEN = $clog2(LEN_MAX);
  localparam int VT_W    = rwv_pkg::VALUE_W + LOG_LEN;
  localparam int VD_W    = rwv_pkg::VOLUME_W + LOG_LEN;
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int RAM_W   = rwv_pkg::VALUE_W + rwv_pkg::VOLUME_W;
  localparam int LW      = rwv_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_INSERT,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t                       state;
  logic [LW-1:0]                window_length;
  logic [LW-1:0]                eff_len;
  logic [VT_W-1:0]              value_total;
  logic [VD_W-1:0]              volume_total;
  logic [LW-1:0]                fill_count;
  logic [AW-1:0]                write_slot;
  logic                         op_q;
  logic [rwv_pkg::VALUE_W-1:0]  value_q;
  logic [rwv_pkg::VOLUME_W-1:0] volume_q;

  logic                         accept;
  logic                         full;
  logic                         vol_zero;
  logic [AW:0]                  slot_inc;
  logic                         slot_wrap;
  logic [RAM_W-1:0]             rd_data;
  logic [rwv_pkg::VALUE_W-1:0]  old_value;
  logic [rwv_pkg::VOLUME_W-1:0] old_volume;
  logic                         div_start;
  logic [VT_W+FRAC_BITS-1:0]    quotient;
  rwv_pkg::div_status_t         div_status;

  // length in use: zero acts as one, oversize clamps to the ring depth, at most 127
  always_comb begin
    if (window_length == '0) begin
      eff_len = LW'(1);
    end else if (32'(window_length) > LEN_MAX) begin
      eff_len = LW'(LEN_MAX);
    end else begin
      eff_len = window_length;
    end
  end

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign full       = (fill_count >= eff_len);
  assign vol_zero   = (volume_total == '0);
  assign slot_inc   = (AW+1)'(write_slot) + (AW+1)'(1);
  assign slot_wrap  = (32'(slot_inc) == 32'(eff_len));
  assign old_value  = rd_data[RAM_W-1 -: rwv_pkg::VALUE_W];
  assign old_volume = rd_data[rwv_pkg::VOLUME_W-1:0];
  assign div_start  = (state == S_START) && !vol_zero;

  // sample ring, read at the slot about to be overwritten
  rwv_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (state == S_INSERT),
    .wr_addr(write_slot),
    .wr_data({value_q, volume_q}),
    .rd_en  (accept),
    .rd_addr(write_slot),
    .rd_data(rd_data)
  );

  // bit-serial divider for the average
  rwv_divider #(
    .NUM_W(VT_W),
    .DEN_W(VD_W),
    .FRAC (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (value_total),
    .den     (volume_total),
    .quotient(quotient),
    .status  (div_status)
  );

  // sequencer, window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= rwv_pkg::WINDOW_RESET;
      value_total   <= '0;
      volume_total  <= '0;
      fill_count    <= '0;
      write_slot    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // result taken downstream, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      // register write empties the window
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        value_total   <= '0;
        volume_total  <= '0;
        fill_count    <= '0;
        write_slot    <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= opcode;
            value_q  <= trade_value;
            volume_q <= trade_volume;
            state    <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (op_q == rwv_pkg::OP_CLEAR) begin
            value_total  <= '0;
            volume_total <= '0;
            fill_count   <= '0;
            write_slot   <= '0;
            state        <= S_START;
          end else begin
            if (full) begin
              value_total  <= value_total - VT_W'(old_value);
              volume_total <= volume_total - VD_W'(old_volume);
            end else begin
              fill_count <= fill_count + LW'(1);
            end
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          value_total  <= value_total + VT_W'(value_q);
          volume_total <= volume_total + VD_W'(volume_q);
          write_slot   <= slot_wrap ? '0 : slot_inc[AW-1:0];
          state        <= S_START;
        end
        S_START: begin
          state <= vol_zero ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            vwap_price  <= vol_zero ? '0 : rwv_pkg::PRICE_W'(quotient);
            zero_volume <= vol_zero;
            window_full <= full;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted item blocks the input until its result is registered
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst) accept |=> in_stall
  ) else $error("input not stalled after a transfer");

  // an empty volume sum always reports a zero price
  a_zero_price: assert property (
    @(posedge clk) disable iff (rst) (out_valid && zero_volume) |-> (vwap_price == '0)
  ) else $error("nonzero price with zero volume");

  // the window never holds more samples than its length
  a_fill_bound: assert property (
    @(posedge clk) disable iff (rst) fill_count <= eff_len
  ) else $error("fill count beyond window length");

  // the write slot stays inside the window
  a_slot_bound: assert property (
    @(posedge clk) disable iff (rst) 32'(write_slot) < 32'(eff_len)
  ) else $error("write slot outside window");

  // the divider only runs while the sequencer waits for it
  a_div_owned: assert property (
    @(posedge clk) disable iff (rst) div_status.busy |-> (state == S_DIV)
  ) else $error("divider busy outside the divide step");

endmodule

/* sim/rolling_window_vwap_tb.sv */
// ----------------------------------------------------------------------------
// rolling_window_vwap_tb: self-checking bench for the rolling window vwap block
// Drives push and clear items with random gaps and output stalls, predicts
// every result from a model of the sample rings and running totals, and
// compares each returned transfer field by field. Covers the window lengths
// at both ends of the register range, long output hold-off and drained pauses.
// ----------------------------------------------------------------------------
module rolling_window_vwap_tb;

  localparam int WIN_MAX      = rwv_pkg::MAX_WINDOW_DEF;
  localparam int FRAC         = rwv_pkg::FRAC_BITS_DEF;
  localparam int SUM_EXTRA    = $clog2(WIN_MAX);
  localparam int VSUM_W       = rwv_pkg::VALUE_W + SUM_EXTRA;
  localparam int WSUM_W       = rwv_pkg::VOLUME_W + SUM_EXTRA;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 170;

  localparam logic [rwv_pkg::PRICE_W-1:0]  PRICE_SAT  = {rwv_pkg::PRICE_W{1'b1}};
  localparam logic [rwv_pkg::VALUE_W-1:0]  VALUE_TOP  = {rwv_pkg::VALUE_W{1'b1}};
  localparam logic [rwv_pkg::VOLUME_W-1:0] VOLUME_TOP = {rwv_pkg::VOLUME_W{1'b1}};

  typedef struct packed {
    logic [rwv_pkg::PRICE_W-1:0] price;
    logic                        full;
    logic                        zero;
  } vwap_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         opcode;
  logic [rwv_pkg::VALUE_W-1:0]  trade_value;
  logic [rwv_pkg::VOLUME_W-1:0] trade_volume;
  logic                         out_valid;
  logic                         out_stall;
  logic [rwv_pkg::PRICE_W-1:0]  vwap_price;
  logic                         window_full;
  logic                         zero_volume;
  logic                         cfg_wr_en;
  logic [rwv_pkg::LEN_W-1:0]    cfg_wr_data;

  rolling_window_vwap #(
    .MAX_WINDOW (WIN_MAX),
    .FRAC_BITS  (FRAC)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .trade_value  (trade_value),
    .trade_volume (trade_volume),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vwap_price   (vwap_price),
    .window_full  (window_full),
    .zero_volume  (zero_volume),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // predictor state: sample history, running totals, length register
  logic [rwv_pkg::VALUE_W-1:0]  value_hist [WIN_MAX];
  logic [rwv_pkg::VOLUME_W-1:0] volume_hist [WIN_MAX];
  logic [VSUM_W-1:0]            value_sum;
  logic [WSUM_W-1:0]            volume_sum;
  int unsigned                  samples_held;
  int unsigned                  next_slot;
  logic [rwv_pkg::LEN_W-1:0]    window_reg;

  vwap_result_t vwap_expected [$];
  int           mismatches;
  int           long_hold;
  bit           sender_calm;
  bit           receiver_calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void empty_history();
    value_sum    = '0;
    volume_sum   = '0;
    samples_held = 0;
    next_slot    = 0;
  endfunction

  // length actually used: zero acts as one, anything above the ring size saturates
  function automatic int unsigned window_span();
    if (window_reg == 0) return 1;
    if (window_reg > WIN_MAX) return 32'(WIN_MAX);
    return 32'(window_reg);
  endfunction

  // advance the window by one item and work out the vwap it reports
  function automatic vwap_result_t predict_vwap(logic op, logic [rwv_pkg::VALUE_W-1:0] value,
                                                logic [rwv_pkg::VOLUME_W-1:0] volume);
    int unsigned  span;
    int unsigned  slot;
    logic [63:0]  quotient;
    vwap_result_t res;
    span = window_span();
    if (op == rwv_pkg::OP_CLEAR) begin
      empty_history();
    end else begin
      slot = next_slot % span;
      // full window: the oldest sample drops out
      if (samples_held >= span) begin
        value_sum  = value_sum - VSUM_W'(value_hist[slot]);
        volume_sum = volume_sum - WSUM_W'(volume_hist[slot]);
      end else begin
        samples_held++;
      end
      value_hist[slot]  = value;
      volume_hist[slot] = volume;
      value_sum  = value_sum + VSUM_W'(value);
      volume_sum = volume_sum + WSUM_W'(volume);
      next_slot  = (slot + 1) % span;
    end
    if (volume_sum == 0) begin
      res.price = '0;
      res.zero  = 1'b1;
    end else begin
      quotient  = (64'(value_sum) << FRAC) / 64'(volume_sum);
      res.price = (quotient > 64'(PRICE_SAT)) ? PRICE_SAT :
                  quotient[rwv_pkg::PRICE_W-1:0];
      res.zero  = 1'b0;
    end
    res.full = (samples_held >= span);
    return res;
  endfunction

  // random payloads weighted towards the extremes
  function automatic logic [rwv_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_TOP;
      1:       return '0;
      2:       return rwv_pkg::VALUE_W'($urandom_range(0, 65535));
      default: return rwv_pkg::VALUE_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [rwv_pkg::VOLUME_W-1:0] rand_volume();
    case ($urandom_range(0, 7))
      0:       return VOLUME_TOP;
      1:       return '0;
      2:       return rwv_pkg::VOLUME_W'($urandom_range(1, 15));
      default: return rwv_pkg::VOLUME_W'($urandom);
    endcase
  endfunction

  // one input transfer, preceded by a random gap
  task automatic send_item(logic op, logic [rwv_pkg::VALUE_W-1:0] value,
                           logic [rwv_pkg::VOLUME_W-1:0] volume);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 23) == 0) sender_calm = !sender_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    trade_value  <= value;
    trade_volume <= volume;
    do @(posedge clk); while (in_stall);
    vwap_expected.push_back(predict_vwap(op, value, volume));
  endtask

  // sender pauses until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (vwap_expected.size() != 0);
  endtask

  // length write, only once the block has gone idle
  task automatic write_window(logic [rwv_pkg::LEN_W-1:0] len);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    window_reg = len;
    empty_history();
  endtask

  // field extremes at the reset length, zero volume and clear items
  task automatic test_reset_extremes();
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, '0);
    send_item(rwv_pkg::OP_PUSH, '0, '0);
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, rwv_pkg::VOLUME_W'(1));
    send_item(rwv_pkg::OP_PUSH, '0, VOLUME_TOP);
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, VOLUME_TOP);
    send_item(rwv_pkg::OP_CLEAR, VALUE_TOP, VOLUME_TOP);
    send_item(rwv_pkg::OP_PUSH, rwv_pkg::VALUE_W'(12345), rwv_pkg::VOLUME_W'(7));
    send_item(rwv_pkg::OP_CLEAR, rand_value(), rand_volume());
  endtask

  // single-sample window, zero length and an over-range length
  task automatic test_length_extremes();
    write_window(rwv_pkg::LEN_W'(1));
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, rwv_pkg::VOLUME_W'(1));
    send_item(rwv_pkg::OP_PUSH, rwv_pkg::VALUE_W'(1), VOLUME_TOP);
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, '0);
    send_item(rwv_pkg::OP_PUSH, '0, rwv_pkg::VOLUME_W'(5));
    write_window('0);
    send_item(rwv_pkg::OP_PUSH, rwv_pkg::VALUE_W'(1000), rwv_pkg::VOLUME_W'(3));
    send_item(rwv_pkg::OP_PUSH, rwv_pkg::VALUE_W'(77), '0);
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, VOLUME_TOP);
    write_window(rwv_pkg::LEN_W'(rwv_pkg::LEN_REG_MAX));
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, rwv_pkg::VOLUME_W'(2));
    send_item(rwv_pkg::OP_PUSH, VALUE_TOP, rwv_pkg::VOLUME_W'(2));
    send_item(rwv_pkg::OP_PUSH, rwv_pkg::VALUE_W'(9), VOLUME_TOP);
    send_item(rwv_pkg::OP_CLEAR, '0, '0);
    write_window(rwv_pkg::WINDOW_RESET);
    send_item(rwv_pkg::OP_PUSH, rand_value(), rand_volume());
  endtask

  // long random runs over a spread of window lengths
  task automatic test_random_windows();
    logic [rwv_pkg::LEN_W-1:0] lengths [11];
    int unsigned               span;
    lengths = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd16, 7'd33, 7'd63, 7'd64, 7'd0, 7'd127, 7'd64};
    lengths[10] = rwv_pkg::LEN_W'($urandom_range(WIN_MAX + 1, rwv_pkg::LEN_REG_MAX - 1));
    foreach (lengths[k]) begin
      write_window(lengths[k]);
      span = window_span();
      // clears rare enough that the window fills and wraps several times
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3 * span + 8) == 0)
          send_item(rwv_pkg::OP_CLEAR, rand_value(), rand_volume());
        else
          send_item(rwv_pkg::OP_PUSH, rand_value(), rand_volume());
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, then a drained pause
  task automatic test_output_hold();
    wait_drained();
    sender_calm = 1'b1;
    long_hold   = HOLD_CYCLES;
    repeat (24) send_item(rwv_pkg::OP_PUSH, rand_value(), rand_volume());
    wait_drained();
    repeat (6) send_item(rwv_pkg::OP_PUSH, rand_value(), rand_volume());
  endtask

  // output stall: per-result random wait, or a long hold when requested
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_left = receiver_calm ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 23) == 0) receiver_calm = !receiver_calm;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  initial begin : result_check
    vwap_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (vwap_expected.size() == 0) begin
          $error("unexpected result: vwap_price %0d window_full %0d zero_volume %0d",
                 vwap_price, window_full, zero_volume);
          mismatches++;
        end else begin
          want = vwap_expected.pop_front();
          if (vwap_price !== want.price) begin
            $error("vwap_price: expected %0d, actual %0d", want.price, vwap_price);
            mismatches++;
          end
          if (window_full !== want.full) begin
            $error("window_full: expected %0d, actual %0d", want.full, window_full);
            mismatches++;
          end
          if (zero_volume !== want.zero) begin
            $error("zero_volume: expected %0d, actual %0d", want.zero, zero_volume);
            mismatches++;
          end
        end
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin : stimulus
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = rwv_pkg::OP_PUSH;
    trade_value   = '0;
    trade_volume  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    mismatches    = 0;
    long_hold     = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    window_reg    = rwv_pkg::WINDOW_RESET;
    empty_history();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_extremes();
    test_length_extremes();
    test_random_windows();
    test_output_hold();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* rolling_window_vwap.f */
design/rwv_pkg.sv
design/rwv_ram.sv
design/rwv_divider.sv
design/rolling_window_vwap.sv
sim/rolling_window_vwap_tb.sv
